// ----- hdl/ssd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seven-segment scan display
// Command codes, field widths, segment table and controller/datapath structs.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int NUM_DIGITS_DEF = 5;
  localparam int NUMBER_W       = 17;
  localparam int PATTERN_W      = 8;
  localparam int DIGIT_W        = 3;
  localparam int CMD_W          = 2;
  localparam int BIT_CNT_W      = $clog2(NUMBER_W);
  localparam int DP_BIT         = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_SHOW     = 2'd1,
    CMD_FILL_ALL = 2'd2,
    CMD_FILL_ONE = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic tick;
    logic fill_all;
    logic fill_one;
    logic conv_load;
    logic conv_shift;
    logic conv_write;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic num_ok;
  } dp_status_t;

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic logic [PATTERN_W-1:0] seg_encode(input logic [3:0] digit);
    logic [PATTERN_W-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ssd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_ctrl: command sequencer
// Decodes accepted items and steps the binary-to-decimal conversion.
// ----------------------------------------------------------------------------
module ssd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [ssd_pkg::CMD_W-1:0] in_command,
  input  ssd_pkg::dp_status_t       status,
  output ssd_pkg::dp_cmd_t          cmd,
  output logic                      busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_WRITE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ssd_pkg::BIT_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (ssd_pkg::cmd_t'(in_command))
            ssd_pkg::CMD_TICK:     cmd.tick = 1'b1;
            ssd_pkg::CMD_FILL_ALL: cmd.fill_all = 1'b1;
            ssd_pkg::CMD_FILL_ONE: cmd.fill_one = 1'b1;
            ssd_pkg::CMD_SHOW: begin
              if (status.num_ok) begin
                cmd.conv_load = 1'b1;
                cnt_nxt       = '0;
                state_nxt     = S_CONV;
              end
            end
            default: ;
          endcase
        end
      end
      S_CONV: begin
        cmd.conv_shift = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == ssd_pkg::BIT_CNT_W'(ssd_pkg::NUMBER_W - 1)) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.conv_write = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ssd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_datapath: pattern buffer, scan index and decimal converter
// Shift-and-add-3 conversion, one input bit per cycle.
// ----------------------------------------------------------------------------
module ssd_datapath #(
  parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  ssd_pkg::dp_cmd_t                   cmd,
  output ssd_pkg::dp_status_t                status,
  input  wire logic [ssd_pkg::NUMBER_W-1:0]  in_number,
  input  wire logic [ssd_pkg::PATTERN_W-1:0] in_pattern,
  input  wire logic [ssd_pkg::DIGIT_W-1:0]   in_position,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  output logic                               out_valid,
  output logic [ssd_pkg::DIGIT_W-1:0]        out_active_digit,
  output logic [ssd_pkg::PATTERN_W-1:0]      out_segments
);

  localparam int IDX_W = $clog2(NUM_DIGITS);
  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam logic [39:0] LIMIT = 40'(ssd_pkg::pow10(NUM_DIGITS));
  localparam logic [ssd_pkg::PATTERN_W-1:0] DP_MASK =
    ssd_pkg::PATTERN_W'(1 << ssd_pkg::DP_BIT);

  logic [ssd_pkg::PATTERN_W-1:0] pat_r [NUM_DIGITS];
  logic [IDX_W-1:0]              scan_r;
  logic [IDX_W-1:0]              scan_nxt;
  logic                          enable_r;
  logic [ssd_pkg::NUMBER_W-1:0]  shift_r;
  logic [BCD_W-1:0]              bcd_r, bcd_nxt;
  logic                          valid_r;
  logic [ssd_pkg::DIGIT_W-1:0]   digit_r;
  logic [ssd_pkg::PATTERN_W-1:0] seg_r;
  logic                          pos_ok;

  assign status.num_ok = (40'(in_number) < LIMIT);
  assign pos_ok        = (32'(in_position) < NUM_DIGITS);
  assign scan_nxt      = (32'(scan_r) == NUM_DIGITS - 1) ? '0 : scan_r + 1'b1;

  // add 3 to every digit of five or more, then shift in the next bit
  always_comb begin
    logic [BCD_W-1:0] adj;
    adj = bcd_r;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end
    end
    bcd_nxt = {adj[BCD_W-2:0], shift_r[ssd_pkg::NUMBER_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      scan_r   <= '0;
      valid_r  <= 1'b0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
        pat_r[d] <= '0;
      end
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      valid_r <= cmd.tick && enable_r;
      if (cmd.tick && enable_r) begin
        scan_r <= scan_nxt;
      end
      if (cmd.fill_all) begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
          pat_r[d] <= in_pattern;
        end
      end
      if (cmd.fill_one && pos_ok) begin
        pat_r[in_position[IDX_W-1:0]] <= in_pattern;
      end
      // top digit also carries the decimal point
      if (cmd.conv_write) begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
          pat_r[d] <= ssd_pkg::seg_encode(bcd_r[4*d +: 4])
                      | ((d == NUM_DIGITS - 1) ? DP_MASK : '0);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      digit_r <= ssd_pkg::DIGIT_W'(scan_nxt);
      seg_r   <= pat_r[scan_nxt];
    end
    if (cmd.conv_load) begin
      shift_r <= in_number;
      bcd_r   <= '0;
    end else if (cmd.conv_shift) begin
      shift_r <= {shift_r[ssd_pkg::NUMBER_W-2:0], 1'b0};
      bcd_r   <= bcd_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_active_digit = digit_r;
  assign out_segments     = seg_r;

endmodule
`default_nettype wire

// ----- hdl/seven_segment_scan_display_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_scan_display_top: multiplexed seven-segment display driver
// Pattern buffer with decimal conversion, raw fills and a scan tick output.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | fields
//  ---------+--------------------+----------------------------------------------
//  in_      | start & !busy      | in_command, in_number, in_pattern, in_position
//  out_     | out_valid (1 clk)  | out_active_digit, out_segments
//  cfg_     | cfg_we             | cfg_wdata (display enable)
//
//  Tick, fill-all and fill-one items leave busy low; a tick accepted while the display
//  is enabled shows its result on the cycle after acceptance. A show-number item in
//  range holds busy while the shift-and-add-3 converter consumes one input bit per
//  cycle and then writes the buffer; out-of-range numbers are dropped without busy.
//  Reset (synchronous, rst_n low) clears the buffer, scan index and enable.
//  Results cannot be stalled: each strobe lasts one cycle and the receiver takes it.
//
module seven_segment_scan_display_top #(
  parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ssd_pkg::CMD_W-1:0]     in_command,
  input  wire logic [ssd_pkg::NUMBER_W-1:0]  in_number,
  input  wire logic [ssd_pkg::PATTERN_W-1:0] in_pattern,
  input  wire logic [ssd_pkg::DIGIT_W-1:0]   in_position,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  output logic                               out_valid,
  output logic [ssd_pkg::DIGIT_W-1:0]        out_active_digit,
  output logic [ssd_pkg::PATTERN_W-1:0]      out_segments
);

  ssd_pkg::dp_cmd_t    dp_cmd;
  ssd_pkg::dp_status_t dp_status;

  // sequencer: decode items, run the conversion
  ssd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (dp_status),
    .cmd        (dp_cmd),
    .busy       (busy)
  );

  // buffer, scan index, converter and result registers
  ssd_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .status           (dp_status),
    .in_number        (in_number),
    .in_pattern       (in_pattern),
    .in_position      (in_position),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_active_digit (out_active_digit),
    .out_segments     (out_segments)
  );

`ifndef ASSERT_OFF
  // a strobe only follows an accepted tick item
  a_valid_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_command == ssd_pkg::CMD_TICK))
    else $error("result strobe without a tick item");

  // lit digit stays inside the display
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_active_digit) < NUM_DIGITS))
    else $error("active digit out of range");

  // only a show-number item raises busy
  a_busy_from_show: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(in_command == ssd_pkg::CMD_SHOW && start))
    else $error("busy raised by a non-conversion item");

  // no strobe during a conversion beyond its first cycle
  a_quiet_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> !out_valid)
    else $error("result strobe during conversion");
`endif

endmodule
`default_nettype wire

// ----- sim/seven_segment_scan_display_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_scan_display_checker: scan result predictor and comparator
// Tracks the digit buffer, scan index and enable, and checks every lit digit.
// ----------------------------------------------------------------------------
module seven_segment_scan_display_checker
  import ssd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [NUMBER_W-1:0]  in_number,
  input  wire logic [PATTERN_W-1:0] in_pattern,
  input  wire logic [DIGIT_W-1:0]   in_position,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  input  wire logic                 out_valid,
  input  wire logic [DIGIT_W-1:0]   out_active_digit,
  input  wire logic [PATTERN_W-1:0] out_segments,
  output int                        error_count,
  output int                        scans_pending
);

  typedef struct packed {
    logic [DIGIT_W-1:0]   digit;
    logic [PATTERN_W-1:0] segs;
  } lit_digit_t;

  lit_digit_t           lit_digits_due[$];
  logic [PATTERN_W-1:0] shown_patterns[NUM_DIGITS];
  logic [DIGIT_W-1:0]   scan_index;
  logic                 scan_enabled;

  function automatic logic [PATTERN_W-1:0] digit_font(input int unsigned d);
    logic [PATTERN_W-1:0] f;
    case (d)
      0:       f = 8'h3f;
      1:       f = 8'h06;
      2:       f = 8'h5b;
      3:       f = 8'h4f;
      4:       f = 8'h66;
      5:       f = 8'h6d;
      6:       f = 8'h7d;
      7:       f = 8'h07;
      8:       f = 8'h7f;
      default: f = 8'h6f;
    endcase
    return f;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s: expected %0h, got %0h at %0d ns", what, want, got, $time);
    error_count++;
  endtask

  // Update the buffer copy for one accepted item; queue the digit a tick lights.
  task automatic track_display(input logic [CMD_W-1:0] cmd, input logic [NUMBER_W-1:0] num,
                               input logic [PATTERN_W-1:0] pat,
                               input logic [DIGIT_W-1:0] pos);
    longint     ceiling;
    longint     rest;
    lit_digit_t lit;
    ceiling = 1;
    for (int i = 0; i < NUM_DIGITS; i++) ceiling = ceiling * 10;
    rest = longint'(num);
    case (cmd)
      CMD_TICK: begin
        if (scan_enabled) begin
          scan_index = (int'(scan_index) >= NUM_DIGITS - 1) ? '0 : scan_index + 1'b1;
          lit.digit  = scan_index;
          lit.segs   = shown_patterns[scan_index];
          lit_digits_due.push_back(lit);
        end
      end
      CMD_SHOW: begin
        if (rest < ceiling) begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            shown_patterns[i] = digit_font(int'(rest % 10));
            rest = rest / 10;
          end
          shown_patterns[NUM_DIGITS-1][DP_BIT] = 1'b1;
        end
      end
      CMD_FILL_ALL: begin
        for (int i = 0; i < NUM_DIGITS; i++) shown_patterns[i] = pat;
      end
      default: begin
        if (int'(pos) < NUM_DIGITS) shown_patterns[pos] = pat;
      end
    endcase
  endtask

  always @(posedge clk) begin
    lit_digit_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) shown_patterns[i] = '0;
      scan_index   = '0;
      scan_enabled = 1'b0;
      lit_digits_due.delete();
    end else begin
      if (out_valid) begin
        if (lit_digits_due.size() == 0) begin
          report_mismatch("unexpected scan result", '0,
                          32'({out_active_digit, out_segments}));
        end else begin
          want = lit_digits_due.pop_front();
          if (out_active_digit !== want.digit)
            report_mismatch("active digit", 32'(want.digit), 32'(out_active_digit));
          if (out_segments !== want.segs)
            report_mismatch("segments", 32'(want.segs), 32'(out_segments));
        end
      end
      if (cfg_we) scan_enabled = cfg_wdata;
      if (start && !busy) track_display(in_command, in_number, in_pattern, in_position);
    end
    scans_pending = lit_digits_due.size();
  end

endmodule

// ----- sim/seven_segment_scan_display_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_scan_display_top_test: testbench for the scan display driver
// Directed and random commands with random gaps over several enable settings.
// ----------------------------------------------------------------------------
module seven_segment_scan_display_top_test;
  import ssd_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  // Settle time: long enough for a show-number item to finish its conversion.
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 115;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_command;
  logic [NUMBER_W-1:0]  in_number;
  logic [PATTERN_W-1:0] in_pattern;
  logic [DIGIT_W-1:0]   in_position;
  logic                 cfg_we;
  logic                 cfg_wdata;
  logic                 out_valid;
  logic [DIGIT_W-1:0]   out_active_digit;
  logic [PATTERN_W-1:0] out_segments;
  int                   error_count;
  int                   scans_pending;
  int                   cycle_count = 0;
  bit                   no_idle     = 1'b0;

  seven_segment_scan_display_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_number        (in_number),
    .in_pattern       (in_pattern),
    .in_position      (in_position),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_active_digit (out_active_digit),
    .out_segments     (out_segments)
  );

  seven_segment_scan_display_checker scan_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_number        (in_number),
    .in_pattern       (in_pattern),
    .in_position      (in_position),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_active_digit (out_active_digit),
    .out_segments     (out_segments),
    .error_count      (error_count),
    .scans_pending    (scans_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Pick an idle gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one item at the falling edge and hold it until the block takes it.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [NUMBER_W-1:0] num,
                              input logic [PATTERN_W-1:0] pat,
                              input logic [DIGIT_W-1:0] pos);
    int gap;
    start       = 1'b1;
    in_command  = cmd;
    in_number   = num;
    in_pattern  = pat;
    in_position = pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    // Keep start high for back-to-back items; drop it only for a real gap.
    gap = pick_gap();
    if (gap > 0) begin
      start       = 1'b0;
      in_command  = CMD_W'($urandom_range(0, 3));
      in_number   = NUMBER_W'($urandom);
      in_pattern  = PATTERN_W'($urandom);
      in_position = DIGIT_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off the sender until every predicted scan result has shown up.
  task automatic wait_scans_drained();
    start = 1'b0;
    while (scans_pending != 0) @(negedge clk);
  endtask

  // Write the enable only while idle: drain, let a conversion finish, then write.
  task automatic write_enable(input logic value);
    wait_scans_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic send_tick();
    send_command(CMD_TICK, NUMBER_W'($urandom), PATTERN_W'($urandom), DIGIT_W'($urandom));
  endtask

  task automatic send_show(input logic [NUMBER_W-1:0] num);
    send_command(CMD_SHOW, num, PATTERN_W'($urandom), DIGIT_W'($urandom));
  endtask

  // Fill every digit with one pattern.
  task automatic send_fill_all(input logic [PATTERN_W-1:0] pat);
    send_command(CMD_FILL_ALL, NUMBER_W'($urandom), pat, DIGIT_W'($urandom));
  endtask

  // Fill one digit with a pattern.
  task automatic send_fill_one(input logic [PATTERN_W-1:0] pat, input logic [DIGIT_W-1:0] pos);
    send_command(CMD_FILL_ONE, NUMBER_W'($urandom), pat, pos);
  endtask

  // One random item: ticks dominate, numbers lean in range, positions lean valid.
  task automatic send_random_item();
    int                   r;
    logic [NUMBER_W-1:0]  num;
    logic [DIGIT_W-1:0]   pos;
    r   = $urandom_range(0, 9);
    num = (r == 0) ? NUMBER_W'($urandom_range(100000, 131071)) :
          (r == 1) ? NUMBER_W'($urandom_range(99990, 100009)) :
          (r == 2) ? NUMBER_W'($urandom_range(0, 20)) :
                     NUMBER_W'($urandom_range(0, 99999));
    pos = ($urandom_range(0, 9) < 8) ? DIGIT_W'($urandom_range(0, 4)) :
                                       DIGIT_W'($urandom_range(5, 7));
    r = $urandom_range(0, 99);
    if (r < 55)      send_tick();
    else if (r < 75) send_show(num);
    else if (r < 85) send_fill_all(PATTERN_W'($urandom));
    else             send_fill_one(PATTERN_W'($urandom), pos);
  endtask

  initial begin
    logic phase_enable[6];
    phase_enable = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    // Drive every input to a known value and hold reset.
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = CMD_TICK;
    in_number   = '0;
    in_pattern  = '0;
    in_position = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A tick before enabling lights nothing.
    send_tick();
    write_enable(1'b1);
    send_tick();                       // cleared buffer, digit 1
    send_show('0);                     // all zeros, point on the top digit
    repeat (5) send_tick();            // walk the index through the wrap
    send_show(17'd99999);
    send_show(17'd100000);             // too large: buffer stays
    send_show(17'h1ffff);              // too large: buffer stays
    repeat (2) send_tick();
    send_fill_all(8'hff);
    send_fill_all(8'h00);
    send_fill_one(8'h80, 3'd4);
    send_fill_one(8'ha5, 3'd0);
    send_fill_one(8'h5a, 3'd5);        // out of range: dropped
    send_fill_one(8'h7e, 3'd7);        // out of range: dropped
    repeat (5) send_tick();
    send_show(17'd12345);
    // Disable: ticks are ignored, fills still land, index is kept.
    write_enable(1'b0);
    send_tick();
    send_fill_one(8'h3c, 3'd2);
    write_enable(1'b1);
    repeat (3) send_tick();

    // Random part: several phases over both enable settings, one without gaps.
    for (int p = 0; p < 6; p++) begin
      write_enable(phase_enable[p]);
      no_idle = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0) wait_scans_drained();
        send_random_item();
      end
    end
    no_idle = 1'b0;

    // Drain, give a last conversion time to finish, then judge.
    wait_scans_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && scans_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
